FILE: rtl/triangle_circumcircle_top_macros.svh
// Assertion shorthands used by the checker of this block.
`ifndef TRIANGLE_CIRCUMCIRCLE_TOP_MACROS_SVH
`define TRIANGLE_CIRCUMCIRCLE_TOP_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define TCC_ASSERT_NOW(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Check a consequence in the cycle after its trigger.
`define TCC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/tcc_pkg.sv
`default_nettype none

package tcc_pkg;

   // Field and datapath widths
   localparam int COORD_W = 24;
   localparam int DIFF_W = COORD_W + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int EF_W = PROD_W + 1;
   localparam int G_W = EF_W + 1;
   localparam int SPLIT = 26;
   localparam int NUM_W = DIFF_W + EF_W + 1;
   localparam int CEN_W = 32;
   localparam int R2_W = 63;
   localparam int RAD_W = 32;
   localparam int THR_W = 16;

   // Threshold after reset
   localparam logic [THR_W-1:0] THR_RESET = 16'd1;

   // Pipeline depths of the divider and the square root
   localparam int DIV_LAT = 36;
   localparam int SQRT_LAT = RAD_W + 1;

   localparam int DEF_QUEUE_DEPTH = 4;

   typedef struct packed {
      logic signed [COORD_W-1:0] vertex0_x;
      logic signed [COORD_W-1:0] vertex0_y;
      logic signed [COORD_W-1:0] vertex1_x;
      logic signed [COORD_W-1:0] vertex1_y;
      logic signed [COORD_W-1:0] vertex2_x;
      logic signed [COORD_W-1:0] vertex2_y;
   } req_type;

   typedef struct packed {
      logic signed [CEN_W-1:0] center_x;
      logic signed [CEN_W-1:0] center_y;
      logic [R2_W-1:0]         radius_squared;
      logic [RAD_W-1:0]        radius;
      logic                    collinear;
      logic                    saturated;
   } rsp_type;

   // One classified triangle handed from the front to the back
   typedef struct packed {
      logic signed [G_W-1:0]     g;
      logic signed [EF_W-1:0]    e;
      logic signed [EF_W-1:0]    f;
      logic signed [DIFF_W-1:0]  a;
      logic signed [DIFF_W-1:0]  b;
      logic signed [DIFF_W-1:0]  c;
      logic signed [DIFF_W-1:0]  d;
      logic signed [COORD_W-1:0] x0;
      logic signed [COORD_W-1:0] y0;
      logic signed [COORD_W-1:0] mid_x;
      logic signed [COORD_W-1:0] mid_y;
      logic signed [COORD_W-1:0] min_x;
      logic signed [COORD_W-1:0] min_y;
      logic                      collinear;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

FILE: rtl/tcc_front.sv
`default_nettype none

module tcc_front import tcc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_data,
   input  wire logic [THR_W-1:0] threshold,
   input  wire queue_status_type queue_status,
   output logic                  push,
   output job_type               push_data
);

   typedef struct packed {
      logic signed [DIFF_W-1:0]  a;
      logic signed [DIFF_W-1:0]  b;
      logic signed [DIFF_W-1:0]  c;
      logic signed [DIFF_W-1:0]  d;
      logic signed [DIFF_W-1:0]  dy21;
      logic signed [DIFF_W-1:0]  dx21;
      logic signed [DIFF_W-1:0]  sx01;
      logic signed [DIFF_W-1:0]  sy01;
      logic signed [DIFF_W-1:0]  sx02;
      logic signed [DIFF_W-1:0]  sy02;
      logic signed [COORD_W-1:0] x0;
      logic signed [COORD_W-1:0] y0;
      logic signed [COORD_W-1:0] min_x;
      logic signed [COORD_W-1:0] max_x;
      logic signed [COORD_W-1:0] min_y;
      logic signed [COORD_W-1:0] max_y;
   } f1_type;

   typedef struct packed {
      logic signed [PROD_W-1:0]  p_ay;
      logic signed [PROD_W-1:0]  p_bx;
      logic signed [PROD_W-1:0]  p_ax;
      logic signed [PROD_W-1:0]  p_by;
      logic signed [PROD_W-1:0]  p_cx;
      logic signed [PROD_W-1:0]  p_dy;
      logic signed [DIFF_W-1:0]  a;
      logic signed [DIFF_W-1:0]  b;
      logic signed [DIFF_W-1:0]  c;
      logic signed [DIFF_W-1:0]  d;
      logic signed [COORD_W-1:0] x0;
      logic signed [COORD_W-1:0] y0;
      logic signed [COORD_W-1:0] mid_x;
      logic signed [COORD_W-1:0] mid_y;
      logic signed [COORD_W-1:0] min_x;
      logic signed [COORD_W-1:0] min_y;
   } f2_type;

   logic                      advance;
   logic                      f0_valid_ff, f1_valid_ff, f2_valid_ff, f3_valid_ff, f4_valid_ff;
   req_type                   vtx_ff;
   f1_type                    f1_in, f1_ff;
   f2_type                    f2_in, f2_ff;
   job_type                   f3_in, f3_ff;
   job_type                   f4_in, f4_ff;
   logic signed [COORD_W-1:0] mn_x, mx_x, mn_y, mx_y;
   logic signed [DIFF_W-1:0]  sum_x, sum_y;
   logic signed [EF_W-1:0]    g_half;
   logic [G_W-1:0]            g_mag;

   // Move everything forward unless a finished item waits on a full queue
   assign advance = !(f4_valid_ff && queue_status.full);
   assign req_ready = advance;
   assign push = f4_valid_ff && !queue_status.full;
   assign push_data = f4_ff;

   // Differences, pair sums and the bounding box
   always_comb begin
      mn_x = (vtx_ff.vertex0_x < vtx_ff.vertex1_x) ? vtx_ff.vertex0_x : vtx_ff.vertex1_x;
      mn_x = (mn_x < vtx_ff.vertex2_x) ? mn_x : vtx_ff.vertex2_x;
      mx_x = (vtx_ff.vertex0_x > vtx_ff.vertex1_x) ? vtx_ff.vertex0_x : vtx_ff.vertex1_x;
      mx_x = (mx_x > vtx_ff.vertex2_x) ? mx_x : vtx_ff.vertex2_x;
      mn_y = (vtx_ff.vertex0_y < vtx_ff.vertex1_y) ? vtx_ff.vertex0_y : vtx_ff.vertex1_y;
      mn_y = (mn_y < vtx_ff.vertex2_y) ? mn_y : vtx_ff.vertex2_y;
      mx_y = (vtx_ff.vertex0_y > vtx_ff.vertex1_y) ? vtx_ff.vertex0_y : vtx_ff.vertex1_y;
      mx_y = (mx_y > vtx_ff.vertex2_y) ? mx_y : vtx_ff.vertex2_y;
      f1_in.a = DIFF_W'(vtx_ff.vertex1_x) - DIFF_W'(vtx_ff.vertex0_x);
      f1_in.b = DIFF_W'(vtx_ff.vertex1_y) - DIFF_W'(vtx_ff.vertex0_y);
      f1_in.c = DIFF_W'(vtx_ff.vertex2_x) - DIFF_W'(vtx_ff.vertex0_x);
      f1_in.d = DIFF_W'(vtx_ff.vertex2_y) - DIFF_W'(vtx_ff.vertex0_y);
      f1_in.dy21 = DIFF_W'(vtx_ff.vertex2_y) - DIFF_W'(vtx_ff.vertex1_y);
      f1_in.dx21 = DIFF_W'(vtx_ff.vertex2_x) - DIFF_W'(vtx_ff.vertex1_x);
      f1_in.sx01 = DIFF_W'(vtx_ff.vertex0_x) + DIFF_W'(vtx_ff.vertex1_x);
      f1_in.sy01 = DIFF_W'(vtx_ff.vertex0_y) + DIFF_W'(vtx_ff.vertex1_y);
      f1_in.sx02 = DIFF_W'(vtx_ff.vertex0_x) + DIFF_W'(vtx_ff.vertex2_x);
      f1_in.sy02 = DIFF_W'(vtx_ff.vertex0_y) + DIFF_W'(vtx_ff.vertex2_y);
      f1_in.x0 = vtx_ff.vertex0_x;
      f1_in.y0 = vtx_ff.vertex0_y;
      f1_in.min_x = mn_x;
      f1_in.max_x = mx_x;
      f1_in.min_y = mn_y;
      f1_in.max_y = mx_y;
   end

   // Products for G, E and F; box midpoint rounded toward minus infinity
   always_comb begin
      sum_x = DIFF_W'(f1_ff.min_x) + DIFF_W'(f1_ff.max_x);
      sum_y = DIFF_W'(f1_ff.min_y) + DIFF_W'(f1_ff.max_y);
      f2_in.p_ay = f1_ff.a * f1_ff.dy21;
      f2_in.p_bx = f1_ff.b * f1_ff.dx21;
      f2_in.p_ax = f1_ff.a * f1_ff.sx01;
      f2_in.p_by = f1_ff.b * f1_ff.sy01;
      f2_in.p_cx = f1_ff.c * f1_ff.sx02;
      f2_in.p_dy = f1_ff.d * f1_ff.sy02;
      f2_in.a = f1_ff.a;
      f2_in.b = f1_ff.b;
      f2_in.c = f1_ff.c;
      f2_in.d = f1_ff.d;
      f2_in.x0 = f1_ff.x0;
      f2_in.y0 = f1_ff.y0;
      f2_in.mid_x = COORD_W'(sum_x >>> 1);
      f2_in.mid_y = COORD_W'(sum_y >>> 1);
      f2_in.min_x = f1_ff.min_x;
      f2_in.min_y = f1_ff.min_y;
   end

   // Sum the products into G, E and F
   always_comb begin
      g_half = EF_W'(f2_ff.p_ay) - EF_W'(f2_ff.p_bx);
      f3_in.g = {g_half, 1'b0};
      f3_in.e = EF_W'(f2_ff.p_ax) + EF_W'(f2_ff.p_by);
      f3_in.f = EF_W'(f2_ff.p_cx) + EF_W'(f2_ff.p_dy);
      f3_in.a = f2_ff.a;
      f3_in.b = f2_ff.b;
      f3_in.c = f2_ff.c;
      f3_in.d = f2_ff.d;
      f3_in.x0 = f2_ff.x0;
      f3_in.y0 = f2_ff.y0;
      f3_in.mid_x = f2_ff.mid_x;
      f3_in.mid_y = f2_ff.mid_y;
      f3_in.min_x = f2_ff.min_x;
      f3_in.min_y = f2_ff.min_y;
      f3_in.collinear = 1'b0;
   end

   // Classify: a zero or small determinant takes the bounding-box path
   always_comb begin
      g_mag = f3_ff.g[G_W-1] ? G_W'(-f3_ff.g) : G_W'(f3_ff.g);
      f4_in = f3_ff;
      f4_in.collinear = (f3_ff.g == '0) || (g_mag < G_W'(threshold));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_valid_ff <= 1'b0;
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
         f4_valid_ff <= 1'b0;
      end else if (advance) begin
         f0_valid_ff <= req_valid;
         f1_valid_ff <= f0_valid_ff;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
         f4_valid_ff <= f3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vtx_ff <= req_data;
         f1_ff <= f1_in;
         f2_ff <= f2_in;
         f3_ff <= f3_in;
         f4_ff <= f4_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/tcc_queue.sv
`default_nettype none

module tcc_queue import tcc_pkg::*; #(
   parameter int DEPTH = DEF_QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire job_type    push_data,
   input  wire logic       pop,
   output job_type         pop_data,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;

   assign status.full = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // Advance pointers and the fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/tcc_div.sv
`default_nettype none

// Rounded quotient num / g, one quotient bit per stage, clipped to 32 bits
module tcc_div import tcc_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    enable,
   input  wire logic signed [NUM_W-1:0] num,
   input  wire logic signed [G_W-1:0]   g,
   output logic signed [CEN_W-1:0]      quo,
   output logic                         sat
);

   localparam int N2_W = NUM_W + 2;
   localparam int D2_W = G_W + 1;
   localparam int Q_W = CEN_W;

   logic [NUM_W-1:0] mag_ff;
   logic [G_W-1:0]   ag_ff;
   logic             neg0_ff, neg1_ff;
   logic [N2_W-1:0]  n2_ff;
   logic [D2_W-1:0]  d2_1_ff;

   logic [D2_W-1:0]  rem_ff [Q_W+1];
   logic [Q_W-1:0]   low_ff [Q_W+1];
   logic [Q_W-1:0]   q_ff   [Q_W+1];
   logic [D2_W-1:0]  d2_ff  [Q_W+1];
   logic             ovf_ff [Q_W+1];
   logic             neg_ff [Q_W+1];

   logic [D2_W:0]    trial  [Q_W];
   logic             take   [Q_W];
   logic [D2_W-1:0]  rem_in [Q_W];

   logic [Q_W-1:0]   lim, q_clip;
   logic             over;

   // Compare and subtract for every quotient bit
   always_comb begin
      for (int k = 0; k < Q_W; k++) begin
         trial[k] = {rem_ff[k], low_ff[k][Q_W-1]};
         take[k] = (trial[k] >= {1'b0, d2_ff[k]});
         rem_in[k] = take[k] ? D2_W'(trial[k] - {1'b0, d2_ff[k]}) : trial[k][D2_W-1:0];
      end
   end

   // Clip and restore the sign
   always_comb begin
      lim = neg_ff[Q_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
      over = ovf_ff[Q_W] || (q_ff[Q_W] > lim);
      q_clip = over ? lim : q_ff[Q_W];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         // magnitudes and sign of the quotient
         mag_ff <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
         ag_ff <= g[G_W-1] ? G_W'(-g) : G_W'(g);
         neg0_ff <= num[NUM_W-1] ^ g[G_W-1];
         // 2|num| + |g| over 2|g| gives round half away from zero
         n2_ff <= (N2_W'(mag_ff) << 1) + N2_W'(ag_ff);
         d2_1_ff <= {ag_ff, 1'b0};
         neg1_ff <= neg0_ff;
         // a quotient of 2^32 or more is caught before the bit loop
         rem_ff[0] <= D2_W'(n2_ff[N2_W-1:Q_W]);
         ovf_ff[0] <= (D2_W'(n2_ff[N2_W-1:Q_W]) >= d2_1_ff);
         low_ff[0] <= n2_ff[Q_W-1:0];
         q_ff[0] <= '0;
         d2_ff[0] <= d2_1_ff;
         neg_ff[0] <= neg1_ff;
         for (int k = 0; k < Q_W; k++) begin
            rem_ff[k+1] <= rem_in[k];
            low_ff[k+1] <= low_ff[k] << 1;
            q_ff[k+1] <= {q_ff[k][Q_W-2:0], take[k]};
            d2_ff[k+1] <= d2_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
            neg_ff[k+1] <= neg_ff[k];
         end
         quo <= neg_ff[Q_W] ? CEN_W'(-q_clip) : CEN_W'(q_clip);
         sat <= over;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/tcc_sqrt.sv
`default_nettype none

// Floor square root, one root bit per stage
module tcc_sqrt import tcc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             enable,
   input  wire logic [R2_W-1:0]  value,
   output logic [RAD_W-1:0]      root
);

   localparam int T_W = 2 * RAD_W + 1;

   logic [R2_W-1:0]  rem_ff  [RAD_W+1];
   logic [RAD_W-1:0] root_ff [RAD_W+1];
   logic [T_W-1:0]   step    [RAD_W];
   logic             take    [RAD_W];

   // (root + 2^i)^2 - root^2 against the remainder
   always_comb begin
      for (int k = 0; k < RAD_W; k++) begin
         step[k] = (T_W'(root_ff[k]) << (RAD_W - k)) + (T_W'(1) << (2 * (RAD_W - 1 - k)));
         take[k] = (T_W'(rem_ff[k]) >= step[k]);
      end
   end

   assign root = root_ff[RAD_W];

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= value;
         root_ff[0] <= '0;
         for (int k = 0; k < RAD_W; k++) begin
            rem_ff[k+1] <= take[k] ? R2_W'(T_W'(rem_ff[k]) - step[k]) : rem_ff[k];
            root_ff[k+1] <= take[k] ? (root_ff[k] | (RAD_W'(1) << (RAD_W - 1 - k)))
                                    : root_ff[k];
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/tcc_back.sv
`default_nettype none

module tcc_back import tcc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire queue_status_type queue_status,
   output logic                  pop,
   input  wire job_type          pop_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_data
);

   localparam int DX_W = CEN_W + 1;
   localparam int SQ_W = 2 * CEN_W;

   typedef struct packed {
      logic                      collinear;
      logic signed [COORD_W-1:0] mid_x;
      logic signed [COORD_W-1:0] mid_y;
      logic signed [COORD_W-1:0] min_x;
      logic signed [COORD_W-1:0] min_y;
      logic signed [COORD_W-1:0] x0;
      logic signed [COORD_W-1:0] y0;
   } side_type;

   typedef struct packed {
      logic signed [CEN_W-1:0] center_x;
      logic signed [CEN_W-1:0] center_y;
      logic [R2_W-1:0]         r2;
      logic                    collinear;
      logic                    saturated;
   } sq_side_type;

   logic                       advance;
   logic                       v0_ff, v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   job_type                    job_ff;
   side_type                   side_in, side1_ff, side2_ff, side3_ff;
   logic signed [G_W-1:0]      g1_ff, g2_ff, g3_ff;
   logic signed [PROD_W-1:0]   de_hi_ff, bf_hi_ff, af_hi_ff, ce_hi_ff;
   logic signed [PROD_W+1:0]   de_lo_ff, bf_lo_ff, af_lo_ff, ce_lo_ff;
   logic signed [NUM_W-1:0]    de_ff, bf_ff, af_ff, ce_ff;
   logic signed [NUM_W-1:0]    num_x_ff, num_y_ff;
   logic signed [CEN_W-1:0]    quo_x, quo_y;
   logic                       sat_x, sat_y;
   logic                       dvalid_ff [DIV_LAT];
   side_type                   dside_ff  [DIV_LAT];
   side_type                   ds;
   logic signed [CEN_W-1:0]    cx_in, cy_in;
   logic signed [COORD_W-1:0]  ref_x, ref_y;
   logic signed [CEN_W-1:0]    cx4_ff, cy4_ff, cx5_ff, cy5_ff, cx6_ff, cy6_ff;
   logic signed [DX_W-1:0]     dx_ff, dy_ff;
   logic [CEN_W-1:0]           adx_ff, ady_ff;
   logic [SQ_W-1:0]            dx2_ff, dy2_ff;
   logic                       coll4_ff, coll5_ff, coll6_ff, sat4_ff, sat5_ff, sat6_ff;
   logic [SQ_W:0]              r2_sum;
   logic                       r2_ovf;
   sq_side_type                sq_in;
   sq_side_type                sq7_ff;
   logic                       svalid_ff [SQRT_LAT];
   sq_side_type                sside_ff  [SQRT_LAT];
   logic [RAD_W-1:0]           root;
   logic                       rsp_valid_ff;
   rsp_type                    rsp_data_ff;

   // The whole back end moves as one while the output register can take a result
   assign advance = !rsp_valid_ff || rsp_ready;
   assign pop = advance && !queue_status.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_comb begin
      side_in.collinear = job_ff.collinear;
      side_in.mid_x = job_ff.mid_x;
      side_in.mid_y = job_ff.mid_y;
      side_in.min_x = job_ff.min_x;
      side_in.min_y = job_ff.min_y;
      side_in.x0 = job_ff.x0;
      side_in.y0 = job_ff.y0;
   end

   tcc_div u_div_x (
      .clock  (clock),
      .enable (advance),
      .num    (num_x_ff),
      .g      (g3_ff),
      .quo    (quo_x),
      .sat    (sat_x)
   );

   tcc_div u_div_y (
      .clock  (clock),
      .enable (advance),
      .num    (num_y_ff),
      .g      (g3_ff),
      .quo    (quo_y),
      .sat    (sat_y)
   );

   // Pick the center and its offset to the reference corner
   always_comb begin
      ds = dside_ff[DIV_LAT-1];
      cx_in = ds.collinear ? CEN_W'(ds.mid_x) : quo_x;
      cy_in = ds.collinear ? CEN_W'(ds.mid_y) : quo_y;
      ref_x = ds.collinear ? ds.min_x : ds.x0;
      ref_y = ds.collinear ? ds.min_y : ds.y0;
   end

   // Sum the squares and clip to 63 bits
   always_comb begin
      r2_sum = (SQ_W+1)'(dx2_ff) + (SQ_W+1)'(dy2_ff);
      r2_ovf = |r2_sum[SQ_W:R2_W];
      sq_in.center_x = cx6_ff;
      sq_in.center_y = cy6_ff;
      sq_in.r2 = r2_ovf ? '1 : r2_sum[R2_W-1:0];
      sq_in.collinear = coll6_ff;
      sq_in.saturated = sat6_ff || r2_ovf;
   end

   tcc_sqrt u_sqrt (
      .clock  (clock),
      .enable (advance),
      .value  (sq7_ff.r2),
      .root   (root)
   );

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < DIV_LAT; k++) begin
            dvalid_ff[k] <= 1'b0;
         end
         for (int k = 0; k < SQRT_LAT; k++) begin
            svalid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         v0_ff <= pop;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         dvalid_ff[0] <= v3_ff;
         for (int k = 1; k < DIV_LAT; k++) begin
            dvalid_ff[k] <= dvalid_ff[k-1];
         end
         v4_ff <= dvalid_ff[DIV_LAT-1];
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         svalid_ff[0] <= v7_ff;
         for (int k = 1; k < SQRT_LAT; k++) begin
            svalid_ff[k] <= svalid_ff[k-1];
         end
         rsp_valid_ff <= svalid_ff[SQRT_LAT-1];
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (advance) begin
         job_ff <= pop_data;
         // split E and F so each multiply stays near 25 by 27 bits
         de_hi_ff <= job_ff.d * $signed(job_ff.e[EF_W-1:SPLIT]);
         de_lo_ff <= job_ff.d * $signed({1'b0, job_ff.e[SPLIT-1:0]});
         bf_hi_ff <= job_ff.b * $signed(job_ff.f[EF_W-1:SPLIT]);
         bf_lo_ff <= job_ff.b * $signed({1'b0, job_ff.f[SPLIT-1:0]});
         af_hi_ff <= job_ff.a * $signed(job_ff.f[EF_W-1:SPLIT]);
         af_lo_ff <= job_ff.a * $signed({1'b0, job_ff.f[SPLIT-1:0]});
         ce_hi_ff <= job_ff.c * $signed(job_ff.e[EF_W-1:SPLIT]);
         ce_lo_ff <= job_ff.c * $signed({1'b0, job_ff.e[SPLIT-1:0]});
         g1_ff <= job_ff.g;
         side1_ff <= side_in;
         // join the partial products
         de_ff <= (NUM_W'(de_hi_ff) <<< SPLIT) + NUM_W'(de_lo_ff);
         bf_ff <= (NUM_W'(bf_hi_ff) <<< SPLIT) + NUM_W'(bf_lo_ff);
         af_ff <= (NUM_W'(af_hi_ff) <<< SPLIT) + NUM_W'(af_lo_ff);
         ce_ff <= (NUM_W'(ce_hi_ff) <<< SPLIT) + NUM_W'(ce_lo_ff);
         g2_ff <= g1_ff;
         side2_ff <= side1_ff;
         // numerators of the center
         num_x_ff <= de_ff - bf_ff;
         num_y_ff <= af_ff - ce_ff;
         g3_ff <= g2_ff;
         side3_ff <= side2_ff;
         // hold side data alongside the dividers
         dside_ff[0] <= side3_ff;
         for (int k = 1; k < DIV_LAT; k++) begin
            dside_ff[k] <= dside_ff[k-1];
         end
         cx4_ff <= cx_in;
         cy4_ff <= cy_in;
         dx_ff <= DX_W'(cx_in) - DX_W'(ref_x);
         dy_ff <= DX_W'(cy_in) - DX_W'(ref_y);
         coll4_ff <= ds.collinear;
         sat4_ff <= !ds.collinear && (sat_x || sat_y);
         // magnitudes of the offsets
         adx_ff <= dx_ff[DX_W-1] ? CEN_W'(-dx_ff) : CEN_W'(dx_ff);
         ady_ff <= dy_ff[DX_W-1] ? CEN_W'(-dy_ff) : CEN_W'(dy_ff);
         cx5_ff <= cx4_ff;
         cy5_ff <= cy4_ff;
         coll5_ff <= coll4_ff;
         sat5_ff <= sat4_ff;
         dx2_ff <= SQ_W'(adx_ff) * SQ_W'(adx_ff);
         dy2_ff <= SQ_W'(ady_ff) * SQ_W'(ady_ff);
         cx6_ff <= cx5_ff;
         cy6_ff <= cy5_ff;
         coll6_ff <= coll5_ff;
         sat6_ff <= sat5_ff;
         sq7_ff <= sq_in;
         // hold results alongside the square root
         sside_ff[0] <= sq7_ff;
         for (int k = 1; k < SQRT_LAT; k++) begin
            sside_ff[k] <= sside_ff[k-1];
         end
         rsp_data_ff.center_x <= sside_ff[SQRT_LAT-1].center_x;
         rsp_data_ff.center_y <= sside_ff[SQRT_LAT-1].center_y;
         rsp_data_ff.radius_squared <= sside_ff[SQRT_LAT-1].r2;
         rsp_data_ff.radius <= root;
         rsp_data_ff.collinear <= sside_ff[SQRT_LAT-1].collinear;
         rsp_data_ff.saturated <= sside_ff[SQRT_LAT-1].saturated;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/triangle_circumcircle_top.sv
// Port    Dir  Handshake              Payload
// req     in   req_valid / req_ready  req_type: three vertices, Q15.8
// rsp     out  rsp_valid / rsp_ready  rsp_type: center, radius^2, radius, flags
// csr     in   csr_wr_en              csr_wr_data: collinear threshold, Q.16
//
// One item per cycle sustained while rsp is not stalled; the path from req to rsp runs
// through the two 36-stage dividers and the 33-stage square root, one result bit per bit stage.
// Reset clears all valid state and loads the threshold with 1.
// A stalled rsp freezes the back end; the front keeps filling the queue
// until it is full, and only then drops req_ready.
`default_nettype none

module triangle_circumcircle_top import tcc_pkg::*; #(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic [THR_W-1:0] csr_wr_data
);

   logic [THR_W-1:0] threshold_ff;
   queue_status_type queue_status;
   logic             push, pop;
   job_type          push_data, pop_data;

   // Threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THR_RESET;
      end else if (csr_wr_en) begin
         threshold_ff <= csr_wr_data;
      end
   end

   tcc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .threshold    (threshold_ff),
      .queue_status (queue_status),
      .push         (push),
      .push_data    (push_data)
   );

   tcc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (queue_status)
   );

   tcc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .pop          (pop),
      .pop_data     (pop_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule

`default_nettype wire

FILE: rtl/tcc_checker.sv
`default_nettype none
`include "triangle_circumcircle_top_macros.svh"

module tcc_checker import tcc_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   localparam int CHK_W = 2 * RAD_W + 2;

   logic [CHK_W-1:0] rad_sq, rad1_sq, r2_ext;

   assign rad_sq = CHK_W'(rsp_data.radius) * CHK_W'(rsp_data.radius);
   assign rad1_sq = (CHK_W'(rsp_data.radius) + CHK_W'(1)) * (CHK_W'(rsp_data.radius) + CHK_W'(1));
   assign r2_ext = CHK_W'(rsp_data.radius_squared);

   // A held result stays put
   `TCC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp item changed while stalled")

   // The bounding-box path never clips
   `TCC_ASSERT_NOW(a_coll_no_sat, !(rsp_valid && rsp_data.collinear && rsp_data.saturated), "collinear item flagged saturated")

   // Radius is the floor square root of the squared radius
   `TCC_ASSERT_NOW(a_radius_root, !rsp_valid || ((rad_sq <= r2_ext) && (rad1_sq > r2_ext)), "radius does not match radius_squared")

endmodule

bind triangle_circumcircle_top tcc_checker u_tcc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

FILE: dv/testbench.sv
`default_nettype none

module testbench;
   import tcc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [THR_W-1:0] csr_wr_data = '0;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 200;

   triangle_circumcircle_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // Circle state shared by predictor and checker
   logic [THR_W-1:0] threshold = THR_RESET;
   rsp_type circles_pending[$];
   int mismatches = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit recv_hold = 1'b0;
   int quiet_cycles = 0;

   // Rounded quotient of num / g, nearest with ties away from zero, clipped
   function automatic logic signed [63:0] round_div(
      input logic signed [127:0] num, input logic signed [63:0] g, inout bit sat);
      logic [127:0] mag_n;
      logic [127:0] mag_g;
      logic [127:0] q;
      bit neg;
      logic [127:0] lim;
      mag_n = num[127] ? -num : num;
      mag_g = g[63] ? -{{64{g[63]}}, g} : {64'd0, g};
      neg = num[127] != g[63];
      lim = neg ? 128'h80000000 : 128'h7FFFFFFF;
      q = (2 * mag_n + mag_g) / (2 * mag_g);
      if (q > lim) begin
         sat = 1'b1;
         q = lim;
      end
      return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
   endfunction

   function automatic logic [31:0] int_sqrt(input logic [62:0] v);
      logic [31:0] r;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
         if ({32'd0, r | (32'd1 << i)} * {32'd0, r | (32'd1 << i)} <= {1'b0, v})
            r = r | (32'd1 << i);
      end
      return r;
   endfunction

   function automatic rsp_type circle_of(input req_type t);
      logic signed [63:0] x0, y0, x1, y1, x2, y2, a, b, c, d, g, e, f;
      logic signed [63:0] cx, cy, dx, dy, mnx, mny, mxx, mxy, s;
      logic [63:0] ag, dx2, dy2, r2;
      bit coll, sat;
      rsp_type r;
      x0 = t.vertex0_x; y0 = t.vertex0_y;
      x1 = t.vertex1_x; y1 = t.vertex1_y;
      x2 = t.vertex2_x; y2 = t.vertex2_y;
      a = x1 - x0; b = y1 - y0; c = x2 - x0; d = y2 - y0;
      g = 2 * (a * (y2 - y1) - b * (x2 - x1));
      ag = g < 0 ? -g : g;
      coll = (g == 0) || (ag < {48'd0, threshold});
      sat = 1'b0;
      if (coll) begin
         mnx = x0 < x1 ? x0 : x1; mnx = mnx < x2 ? mnx : x2;
         mxx = x0 > x1 ? x0 : x1; mxx = mxx > x2 ? mxx : x2;
         mny = y0 < y1 ? y0 : y1; mny = mny < y2 ? mny : y2;
         mxy = y0 > y1 ? y0 : y1; mxy = mxy > y2 ? mxy : y2;
         s = mnx + mxx; cx = s >>> 1;
         s = mny + mxy; cy = s >>> 1;
         dx = cx - mnx; dy = cy - mny;
      end else begin
         e = a * (x0 + x1) + b * (y0 + y1);
         f = c * (x0 + x2) + d * (y0 + y2);
         cx = round_div(128'(d) * 128'(e) - 128'(b) * 128'(f), g, sat);
         cy = round_div(128'(a) * 128'(f) - 128'(c) * 128'(e), g, sat);
         dx = cx - x0; dy = cy - y0;
      end
      dx2 = dx < 0 ? -dx : dx; dx2 = dx2 * dx2;
      dy2 = dy < 0 ? -dy : dy; dy2 = dy2 * dy2;
      if (dx2 > 64'h7FFFFFFFFFFFFFFF || dy2 > 64'h7FFFFFFFFFFFFFFF - dx2) begin
         r2 = 64'h7FFFFFFFFFFFFFFF;
         sat = 1'b1;
      end else begin
         r2 = dx2 + dy2;
      end
      r.center_x = cx[31:0];
      r.center_y = cy[31:0];
      r.radius_squared = r2[62:0];
      r.radius = int_sqrt(r2[62:0]);
      r.collinear = coll;
      r.saturated = sat;
      return r;
   endfunction

   // Send one item, honoring the sender idle rate; valid stays up between items unless an idle cycle is drawn
   task automatic send_triangle(input req_type t);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      circles_pending.insert(circles_pending.size(), circle_of(t));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (circles_pending.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic write_threshold(input logic [THR_W-1:0] v);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      threshold = v;
   endtask

   function automatic req_type make_tri(input int x0, y0, x1, y1, x2, y2);
      req_type t;
      t.vertex0_x = 24'(x0); t.vertex0_y = 24'(y0);
      t.vertex1_x = 24'(x1); t.vertex1_y = 24'(y1);
      t.vertex2_x = 24'(x2); t.vertex2_y = 24'(y2);
      return t;
   endfunction

   function automatic logic [23:0] rand_coord();
      case ($urandom_range(3))
         0: return 24'($urandom);
         1: return 24'($signed($urandom_range(4000)) - 2000);
         2: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
         default: return 24'($signed($urandom_range(200000)) - 100000);
      endcase
   endfunction

   function automatic req_type rand_triangle();
      req_type t;
      t = make_tri(rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord(), rand_coord());
      // Force near-collinear triangles now and then
      if ($urandom_range(9) == 0) begin
         t.vertex2_x = t.vertex1_x;
         t.vertex2_y = t.vertex1_y + 24'($urandom_range(2));
      end else if ($urandom_range(9) == 0) begin
         t.vertex1_x = t.vertex0_x + 24'($urandom_range(3));
         t.vertex2_x = t.vertex0_x + 24'($urandom_range(3));
      end
      return t;
   endfunction

   task automatic test_directed();
      send_triangle(make_tri(0, 0, 256, 0, 0, 256));
      send_triangle(make_tri(0, 0, 0, 0, 0, 0));
      send_triangle(make_tri(0, 0, 256, 256, 512, 512));
      send_triangle(make_tri(-8388608, -8388608, 8388607, -8388608, -8388608, 8388607));
      send_triangle(make_tri(8388607, 8388607, -8388608, 8388607, 8388607, -8388608));
      send_triangle(make_tri(-8388608, 8388607, 8388607, -8388608, 0, 0));
      send_triangle(make_tri(0, 0, 1, 0, 0, 1));
      send_triangle(make_tri(0, 0, 1, 1, 8388607, 8388606));
      send_triangle(make_tri(-8388608, -8388608, 8388607, 8388607, 8388607, 8388606));
      send_triangle(make_tri(-3, -5, -1, -7, 3, 9));
      send_triangle(make_tri(-1, -1, -2, -2, -3, -3));
      send_triangle(make_tri(0, 0, 3, 0, 0, 1));
      send_triangle(make_tri(0, 0, 1, 0, 1, 1));
      send_triangle(make_tri(0, 0, 8388607, 1, -8388608, -1));
   endtask

   task automatic test_random(input int count);
      repeat (count) send_triangle(rand_triangle());
   endtask

   task automatic test_threshold_sweep();
      write_threshold(16'd0);
      send_triangle(make_tri(0, 0, 0, 0, 0, 0));
      send_triangle(make_tri(0, 0, 1, 0, 0, 1));
      test_random(60);
      write_threshold(16'hFFFF);
      send_triangle(make_tri(0, 0, 100, 0, 0, 100));
      send_triangle(make_tri(0, 0, 200, 0, 0, 200));
      test_random(60);
      write_threshold(16'd2);
      send_triangle(make_tri(0, 0, 1, 0, 0, 1));
      write_threshold(16'($urandom));
      test_random(60);
      write_threshold(THR_RESET);
   endtask

   // Receiver holds off while the sender keeps offering items
   task automatic test_backpressure();
      wait_drained();
      recv_hold = 1'b1;
      fork
         begin
            repeat (300) @(negedge clock);
            recv_hold = 1'b0;
         end
         test_random(120);
      join
      // Sender pauses until every result is back
      wait_drained();
      test_random(40);
   endtask

   // Receiver ready with random stalls
   always @(negedge clock) begin
      if (recv_hold) rsp_ready <= 1'b0;
      else rsp_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
   end

   // Check each accepted result against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (circles_pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            rsp_type want;
            want = circles_pending.pop_front();
            if (want !== rsp_data) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", want, rsp_data);
            end
         end
      end
   end

   // Watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      send_idle_pct = 15;
      recv_idle_pct = 84;
      test_threshold_sweep();
      test_random(350);
      send_idle_pct = 84;
      recv_idle_pct = 15;
      test_random(350);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_random(350);
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && circles_pending.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

`default_nettype wire
